FILE: src/sfir_pkg.sv
// Shared types and constants for the nine-tap symmetric shift-add FIR filter.
package sfir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TAPS     = 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample [TAPS-1:0]          t_taps;

endpackage

FILE: src/sfir_if.sv
// Valid/ready stream interfaces for the input samples and the filtered results.
interface sfir_in_if;
    logic              valid;
    logic              ready;
    sfir_pkg::t_sample sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface sfir_out_if;
    logic              valid;
    logic              ready;
    sfir_pkg::t_sample filtered_value;

    modport source (output valid, output filtered_value, input ready);
    modport sink   (input valid, input filtered_value, output ready);
endinterface

FILE: src/symmetric_fir9_shift_add.sv
// Top level of the nine-tap symmetric shift-add FIR filter.
// The filter takes one signed Q5.10 sample per cycle and returns one wrapped Q5.10 result
// per sample, in the cycle after the sample is accepted, from an output register. A new
// sample is accepted in every cycle in which the output register is empty or its result
// is being taken, so the sustained rate is one sample per clock whenever the sink keeps
// ready high; the output register alone sets that figure. The delay line is a row of
// eight cells that reset to zero, and each result uses the delay line as it stood before
// its own sample was shifted in.
module symmetric_fir9_shift_add (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfir_in_if.sink    i_sample,
    sfir_out_if.source o_filtered
);

    sfir_pkg::t_taps   taps;
    sfir_pkg::t_sample y;
    logic              accept;

    logic              r_out_valid;
    logic              n_out_valid;
    sfir_pkg::t_sample r_filtered;
    sfir_pkg::t_sample n_filtered;

    assign i_sample.ready = !r_out_valid || o_filtered.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    for (genvar g = 0; g < sfir_pkg::TAPS; g++) begin : g_cell
        if (g == 0) begin : g_head
            sfir_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_data  (i_sample.sample_value),
                .o_data  (taps[g])
            );
        end else begin : g_body
            sfir_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_data  (taps[g-1]),
                .o_data  (taps[g])
            );
        end
    end

    sfir_combine u_combine (
        .i_x0   (i_sample.sample_value),
        .i_taps (taps),
        .o_y    (y)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_filtered  = r_filtered;
        if (accept) begin
            n_out_valid = 1'b1;
            n_filtered  = y;
        end else if (o_filtered.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_filtered <= n_filtered;
    end

    assign o_filtered.valid          = r_out_valid;
    assign o_filtered.filtered_value = r_filtered;

endmodule

FILE: src/sfir_tap_cell.sv
// One delay-line cell: holds a sample and passes it to its neighbor on each shift.
module sfir_tap_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  sfir_pkg::t_sample i_data,
    output sfir_pkg::t_sample o_data
);

    sfir_pkg::t_sample r_data;
    sfir_pkg::t_sample n_data;

    always_comb begin
        n_data = i_shift ? i_data : r_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: src/sfir_combine.sv
// Shift-add datapath that folds the symmetric taps into one filtered value.
module sfir_combine (
    input  sfir_pkg::t_sample i_x0,
    input  sfir_pkg::t_taps   i_taps,
    output sfir_pkg::t_sample o_y
);

    sfir_pkg::t_sample d, a, b, c;
    sfir_pkg::t_sample p1, q, r, s, p2;

    // Sums wrap to the sample width; arithmetic shifts round toward minus infinity.
    assign d  = i_x0 + i_taps[7];
    assign a  = i_taps[0] + i_taps[6];
    assign b  = i_taps[1] + i_taps[5];
    assign c  = i_taps[2] + i_taps[4];

    assign p1 = i_taps[3] + (a >>> 2);
    assign q  = c + (c >>> 2);
    assign r  = b - (b >>> 2);
    assign s  = q - r;
    assign p2 = (d >>> 3) + p1;
    assign o_y = p2 + s;

endmodule

FILE: src/sfir_checker.sv
// Port-level checker for the FIR filter, bound to its top level.
module sfir_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input sfir_pkg::t_sample i_out_data
);

    logic in_xact;
    logic out_stall;

    assign in_xact   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // A result that waits must stay put until its transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed or vanished");

    // Every accepted sample shows its result in the next cycle.
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact |=> i_out_valid)
        else $error("accepted sample produced no result");

    // No result appears without an input transaction behind it.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xact && !out_stall |=> !i_out_valid)
        else $error("result appeared without an input");

    // Input is refused only while a finished result is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> out_stall)
        else $error("input refused while output could drain");

endmodule

bind symmetric_fir9_shift_add sfir_checker u_sfir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_filtered.valid),
    .i_out_ready (o_filtered.ready),
    .i_out_data  (o_filtered.filtered_value)
);
